// ===== hw/rtl/tehl_pkg.sv =====
// Shared types and constants of the tremor envelope to haptic level unit.
package tehl_pkg;

    // Field widths of the words on both channels.
    localparam int ACCEL_W = 16;
    localparam int MAG_W   = 16;
    localparam int ENV_W   = 24;
    localparam int LVL_W   = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Largest envelope value.
    localparam logic [ENV_W-1:0] ENV_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_COEFF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TREMOR_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL        = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [15:0]      RST_SMOOTHING_COEFF  = 16'd55706;
    localparam logic [15:0]      RST_GRAVITY_OFFSET   = 16'd8192;
    localparam logic [15:0]      RST_TREMOR_THRESHOLD = 16'd287;
    localparam logic [15:0]      RST_FULL_SCALE_LEVEL = 16'd1638;
    localparam logic [LVL_W-1:0] RST_MIN_LEVEL        = 7'd0;
    localparam logic [LVL_W-1:0] RST_MAX_LEVEL        = 7'd127;

    // Input word: one accelerometer sample.
    typedef struct packed {
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_z;
        logic                      sample_valid;
    } in_word_t;

    // Output word: drive level, envelope and magnitude used.
    typedef struct packed {
        logic [LVL_W-1:0] haptic_level;
        logic [ENV_W-1:0] tremor_envelope;
        logic [MAG_W-1:0] magnitude;
    } out_word_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_LP_MUL,
        ST_LP_UPD,
        ST_HP,
        ST_ENV_MUL,
        ST_ENV_UPD,
        ST_LVL,
        ST_DIV,
        ST_LVL_FIN,
        ST_DONE
    } seq_state_t;

endpackage

// ===== hw/rtl/tremor_envelope_to_haptic_level_unit.sv =====
// Top level of the tremor envelope to haptic level unit: sequencer and shared datapath.

// One accelerometer word is taken at a time. For a word with a new sample, the three squares
// are formed on the shared multiplier. A 16-step square root and a 9-step level division run
// on the shared subtractor. Further steps cover the two filters, the level mapping and the
// hand-over. A word that reuses the held magnitude skips the squares and the root. An
// envelope below the threshold, or a full scale not above it, skips the division and its final
// step. The unit is ready again in the same cycle as the result appears. The result sits in an
// output register, so the next word is accepted as soon as the sequencer is idle, even while
// the previous result still waits to be taken. Configuration registers are written through a
// plain write port with no wait, and should only be written while the unit is idle.
module tremor_envelope_to_haptic_level_unit #(
    parameter int FILTER_FRAC_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  tehl_pkg::in_word_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output tehl_pkg::out_word_t                   m_data,
    input  logic                                  cfg_wr_en,
    input  logic [tehl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tehl_pkg::CFG_W-1:0]            cfg_wr_data
);

    localparam int F       = FILTER_FRAC_BITS;
    localparam int MOV_W   = 17 + F;                   // movement and low-pass value
    localparam int DIF_W   = MOV_W + 1;                // filter differences
    localparam int D_W     = (DIF_W > 25) ? DIF_W : 25; // multiplier B operand
    localparam int P_W     = 17 + D_W;                 // product
    localparam int THR_W   = 16 + F;                   // scaled threshold and span
    localparam int CMP_W   = (THR_W > 24) ? THR_W : 24;
    localparam int RW      = (DIF_W > 25) ? DIF_W : 25;
    localparam int SUB_W   = (THR_W + 8 > 32) ? THR_W + 8 : 32;

    // Configuration registers.
    logic [15:0]                    coef_reg, coef_next;
    logic [15:0]                    grav_reg, grav_next;
    logic [15:0]                    thr_reg, thr_next;
    logic [15:0]                    fsl_reg, fsl_next;
    logic [tehl_pkg::LVL_W-1:0]     min_reg, min_next;
    logic [tehl_pkg::LVL_W-1:0]     max_reg, max_next;

    // Sequencer and working registers.
    tehl_pkg::seq_state_t           st_reg, st_next;
    logic [3:0]                     cnt_reg, cnt_next;
    logic signed [15:0]             x_reg, x_next;
    logic signed [15:0]             y_reg, y_next;
    logic signed [15:0]             z_reg, z_next;
    logic [31:0]                    acc_reg, acc_next;
    logic [31:0]                    root_reg, root_next;
    logic [8:0]                     q_reg, q_next;
    logic signed [P_W-1:0]          prod_reg, prod_next;
    logic signed [MOV_W-1:0]        mov_reg, mov_next;
    logic [tehl_pkg::ENV_W-1:0]     rect_reg, rect_next;
    logic [tehl_pkg::LVL_W-1:0]     lvl_reg, lvl_next;

    // Filter state.
    logic [tehl_pkg::MAG_W-1:0]     mag_reg, mag_next;
    logic signed [MOV_W-1:0]        lp_reg, lp_next;
    logic [tehl_pkg::ENV_W-1:0]     env_reg, env_next;

    // Output register.
    logic                           m_valid_reg, m_valid_next;
    tehl_pkg::out_word_t            m_data_reg, m_data_next;

    // Shared multiplier and subtractor.
    logic signed [16:0]             mul_a;
    logic signed [D_W-1:0]          mul_b;
    logic signed [P_W-1:0]          mul_p;
    logic [SUB_W-1:0]               sub_a;
    logic [SUB_W-1:0]               sub_b;
    logic [SUB_W:0]                 sub_res;
    logic                           sub_ge;

    // Helper values.
    logic [31:0]                    sq_bit;
    logic [31:0]                    sq_trial;
    logic signed [15:0]             sq_src;
    logic signed [16:0]             mag_diff;
    logic signed [MOV_W-1:0]        mov_val;
    logic signed [DIF_W-1:0]        lp_d;
    logic signed [24:0]             env_d;
    logic signed [P_W:0]            prod_ext;
    logic signed [P_W:0]            prod_sh;
    logic signed [DIF_W-1:0]        lp_sum;
    logic signed [DIF_W-1:0]        hp_val;
    logic [DIF_W-1:0]               hp_abs;
    logic signed [25:0]             env_sum;
    logic [THR_W-1:0]               thr_s;
    logic [THR_W-1:0]               span;
    logic [tehl_pkg::ENV_W-1:0]     lvl_diff;
    logic                           env_below;
    logic [tehl_pkg::LVL_W-1:0]     add_lvl;
    logic [tehl_pkg::LVL_W:0]       lvl_sum;

    assign s_ready = (st_reg == tehl_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Values derived from state and configuration.
    always_comb begin
        sq_bit   = 32'd1 << {cnt_reg, 1'b0};
        sq_trial = root_reg + sq_bit;
        mag_diff = $signed({1'b0, mag_reg}) - $signed({1'b0, grav_reg});
        mov_val  = MOV_W'(mag_diff) <<< F;
        lp_d     = DIF_W'(lp_reg) - DIF_W'(mov_val);
        env_d    = $signed({1'b0, env_reg}) - $signed({1'b0, rect_reg});
        prod_ext = (P_W+1)'(prod_reg) + (P_W+1)'($signed({1'b0, 16'h8000}));
        prod_sh  = prod_ext >>> 16;
        lp_sum   = DIF_W'(mov_reg) + DIF_W'(prod_sh);
        hp_val   = DIF_W'(mov_reg) - DIF_W'(lp_reg);
        hp_abs   = hp_val[DIF_W-1] ? DIF_W'(-hp_val) : DIF_W'(hp_val);
        env_sum  = 26'($signed({1'b0, rect_reg})) + 26'(prod_sh);
        thr_s    = THR_W'(thr_reg) << F;
        span     = THR_W'(fsl_reg - thr_reg) << F;
        env_below = CMP_W'(env_reg) < CMP_W'(thr_s);
        lvl_diff = tehl_pkg::ENV_W'(CMP_W'(env_reg) - CMP_W'(thr_s));
        add_lvl  = (q_reg > {2'b00, max_reg}) ? max_reg : q_reg[tehl_pkg::LVL_W-1:0];
        lvl_sum  = {1'b0, min_reg} + {1'b0, add_lvl};
    end

    // Square source for the current square step.
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    sq_src = x_reg;
            2'd1:    sq_src = y_reg;
            default: sq_src = z_reg;
        endcase
    end

    // Shared multiplier operand selection.
    always_comb begin
        case (st_reg)
            tehl_pkg::ST_SQ: begin
                mul_a = 17'(sq_src);
                mul_b = D_W'(sq_src);
            end
            tehl_pkg::ST_LP_MUL: begin
                mul_a = $signed({1'b0, coef_reg});
                mul_b = D_W'(lp_d);
            end
            tehl_pkg::ST_ENV_MUL: begin
                mul_a = $signed({1'b0, coef_reg});
                mul_b = D_W'(env_d);
            end
            tehl_pkg::ST_LVL: begin
                mul_a = $signed(17'(max_reg));
                mul_b = $signed(D_W'(lvl_diff));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = P_W'(mul_a) * P_W'(mul_b);
    end

    // Shared subtractor: square-root and division steps.
    always_comb begin
        case (st_reg)
            tehl_pkg::ST_SQRT: begin
                sub_a = SUB_W'(acc_reg);
                sub_b = SUB_W'(sq_trial);
            end
            tehl_pkg::ST_DIV: begin
                sub_a = SUB_W'(acc_reg);
                sub_b = SUB_W'(span) << cnt_reg;
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        sub_res = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge  = !sub_res[SUB_W];
    end

    // Sequencer: next state and next register values.
    always_comb begin
        st_next      = st_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        acc_next     = acc_reg;
        root_next    = root_reg;
        q_next       = q_reg;
        prod_next    = prod_reg;
        mov_next     = mov_reg;
        rect_next    = rect_reg;
        lvl_next     = lvl_reg;
        mag_next     = mag_reg;
        lp_next      = lp_reg;
        env_next     = env_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        coef_next    = coef_reg;
        grav_next    = grav_reg;
        thr_next     = thr_reg;
        fsl_next     = fsl_reg;
        min_next     = min_reg;
        max_next     = max_reg;

        // The downstream side takes the waiting result.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (st_reg)
            tehl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    x_next   = s_data.accel_x;
                    y_next   = s_data.accel_y;
                    z_next   = s_data.accel_z;
                    acc_next = '0;
                    cnt_next = '0;
                    st_next  = s_data.sample_valid ? tehl_pkg::ST_SQ : tehl_pkg::ST_LP_MUL;
                end
            end
            tehl_pkg::ST_SQ: begin
                // Squares are issued in steps 0 to 2; each is held in the product register and summed in steps 1 to 3.
                prod_next = mul_p;
                if (cnt_reg != 4'd0) begin
                    acc_next = acc_reg + prod_reg[31:0];
                end
                if (cnt_reg == 4'd3) begin
                    cnt_next  = 4'd15;
                    root_next = '0;
                    st_next   = tehl_pkg::ST_SQRT;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            tehl_pkg::ST_SQRT: begin
                // One result bit per cycle, the largest first.
                if (sub_ge) begin
                    acc_next  = sub_res[31:0];
                    root_next = (root_reg >> 1) + sq_bit;
                end else begin
                    root_next = root_reg >> 1;
                end
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) begin
                    mag_next = root_next[tehl_pkg::MAG_W-1:0];
                    st_next  = tehl_pkg::ST_LP_MUL;
                end
            end
            tehl_pkg::ST_LP_MUL: begin
                mov_next  = mov_val;
                prod_next = mul_p;
                st_next   = tehl_pkg::ST_LP_UPD;
            end
            tehl_pkg::ST_LP_UPD: begin
                lp_next = MOV_W'(lp_sum);
                st_next = tehl_pkg::ST_HP;
            end
            tehl_pkg::ST_HP: begin
                // Rectify the high-pass value and saturate it to the envelope width.
                if (RW'(hp_abs) > RW'(tehl_pkg::ENV_MAX)) begin
                    rect_next = tehl_pkg::ENV_MAX;
                end else begin
                    rect_next = tehl_pkg::ENV_W'(hp_abs);
                end
                st_next = tehl_pkg::ST_ENV_MUL;
            end
            tehl_pkg::ST_ENV_MUL: begin
                prod_next = mul_p;
                st_next   = tehl_pkg::ST_ENV_UPD;
            end
            tehl_pkg::ST_ENV_UPD: begin
                env_next = env_sum[tehl_pkg::ENV_W-1:0];
                st_next  = tehl_pkg::ST_LVL;
            end
            tehl_pkg::ST_LVL: begin
                // Below threshold, a step to full drive, or the linear mapping.
                if (env_below) begin
                    lvl_next = (min_reg > max_reg) ? max_reg : min_reg;
                    st_next  = tehl_pkg::ST_DONE;
                end else if (fsl_reg <= thr_reg) begin
                    lvl_next = max_reg;
                    st_next  = tehl_pkg::ST_DONE;
                end else begin
                    prod_next = mul_p;
                    acc_next  = 32'(mul_p[30:0]);
                    q_next    = '0;
                    cnt_next  = 4'd8;
                    st_next   = tehl_pkg::ST_DIV;
                end
            end
            tehl_pkg::ST_DIV: begin
                // Restoring division, nine quotient bits; anything larger clamps anyway.
                if (sub_ge) begin
                    acc_next = sub_res[31:0];
                end
                q_next   = {q_reg[7:0], sub_ge};
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) begin
                    st_next = tehl_pkg::ST_LVL_FIN;
                end
            end
            tehl_pkg::ST_LVL_FIN: begin
                if (lvl_sum > {1'b0, max_reg}) begin
                    lvl_next = max_reg;
                end else begin
                    lvl_next = lvl_sum[tehl_pkg::LVL_W-1:0];
                end
                st_next = tehl_pkg::ST_DONE;
            end
            tehl_pkg::ST_DONE: begin
                // Hand the word over once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.haptic_level    = lvl_reg;
                    m_data_next.tremor_envelope = env_reg;
                    m_data_next.magnitude       = mag_reg;
                    st_next                     = tehl_pkg::ST_IDLE;
                end
            end
            default: begin
                st_next = tehl_pkg::ST_IDLE;
            end
        endcase

        // Configuration writes; unknown indexes are ignored.
        if (cfg_wr_en) begin
            case (cfg_index)
                tehl_pkg::REG_SMOOTHING_COEFF:  coef_next = cfg_wr_data;
                tehl_pkg::REG_GRAVITY_OFFSET:   grav_next = cfg_wr_data;
                tehl_pkg::REG_TREMOR_THRESHOLD: thr_next  = cfg_wr_data;
                tehl_pkg::REG_FULL_SCALE_LEVEL: fsl_next  = cfg_wr_data;
                tehl_pkg::REG_MIN_LEVEL:        min_next  = cfg_wr_data[tehl_pkg::LVL_W-1:0];
                tehl_pkg::REG_MAX_LEVEL:        max_next  = cfg_wr_data[tehl_pkg::LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control, configuration and filter state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= tehl_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            mag_reg     <= '0;
            lp_reg      <= '0;
            env_reg     <= '0;
            coef_reg    <= tehl_pkg::RST_SMOOTHING_COEFF;
            grav_reg    <= tehl_pkg::RST_GRAVITY_OFFSET;
            thr_reg     <= tehl_pkg::RST_TREMOR_THRESHOLD;
            fsl_reg     <= tehl_pkg::RST_FULL_SCALE_LEVEL;
            min_reg     <= tehl_pkg::RST_MIN_LEVEL;
            max_reg     <= tehl_pkg::RST_MAX_LEVEL;
        end else begin
            st_reg      <= st_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            mag_reg     <= mag_next;
            lp_reg      <= lp_next;
            env_reg     <= env_next;
            coef_reg    <= coef_next;
            grav_reg    <= grav_next;
            thr_reg     <= thr_next;
            fsl_reg     <= fsl_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        acc_reg    <= acc_next;
        root_reg   <= root_next;
        q_reg      <= q_next;
        prod_reg   <= prod_next;
        mov_reg    <= mov_next;
        rect_reg   <= rect_next;
        lvl_reg    <= lvl_next;
        m_data_reg <= m_data_next;
    end

endmodule
